/* rtl/awt_pkg.sv */
// ----------------------------------------------------------------------------
// awt_pkg
// Shared constants, CORDIC arctangent table and pipeline record types.
// ----------------------------------------------------------------------------
package awt_pkg;

  localparam int          CORDIC_STEPS_DEF = 16;
  localparam int          ATAN_ENTRIES     = 24;
  localparam int          FRAC_BITS        = 16;
  localparam logic [11:0] ANGLE_TENTHS     = 12'd3600;
  localparam logic [11:0] SPEED_MAX        = 12'd4095;
  localparam logic [31:0] HALF_TURN        = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN     = 32'h4000_0000;
  localparam logic [28:0] INV_GAIN_SQ_Q30  = 29'd395948878;
  // tenths -> turns: a*2^32/3600 = a*TURN_INT + (a*TURN_REM + 112)/225
  localparam logic [31:0] TURN_INT         = 32'd1193046;
  localparam logic [18:0] TURN_REM         = 19'd106;
  localparam logic [18:0] TURN_RND         = 19'd112;
  localparam logic [37:0] RECIP_225        = 38'd596524;  // ceil(2^27/225)

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        z;
  } vec_t;

  typedef struct packed {
    vec_t        wind;
    vec_t        boat;
    logic [11:0] course;
  } rot_t;

  typedef struct packed {
    vec_t        c;
    logic        zero;
    logic [11:0] course;
  } vrec_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/apparent_wind_from_true_wind.sv */
// Register stages in order: front end, CORDIC rotation steps, vectoring pre-step, vectoring steps, back end.
// Throughput: one request per cycle while not stalled; each CORDIC iteration is its own register stage.
// A stall on a valid output freezes the whole pipeline; in_stall follows it directly.
// Reset (rst, synchronous) clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// apparent_wind_from_true_wind
// Apparent wind vector from true wind and boat motion via pipelined CORDIC.
// ----------------------------------------------------------------------------
module apparent_wind_from_true_wind import awt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] true_wind_angle,
  input  logic [10:0] true_wind_speed,
  input  logic [11:0] course_angle,
  input  logic [9:0]  ground_speed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] apparent_angle,
  output logic [11:0] apparent_speed
);

  logic  en;
  logic  rot_v [CORDIC_STEPS+1];
  rot_t  rot_d [CORDIC_STEPS+1];
  logic  vec_v [CORDIC_STEPS+1];
  vrec_t vec_d [CORDIC_STEPS+1];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  awt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (in_valid),
    .true_wind_angle (true_wind_angle),
    .true_wind_speed (true_wind_speed),
    .course_angle    (course_angle),
    .ground_speed    (ground_speed),
    .out_valid       (rot_v[0]),
    .out_item        (rot_d[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    awt_rot_step #(.STEP(i)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (rot_v[i]),
      .in_item   (rot_d[i]),
      .out_valid (rot_v[i+1]),
      .out_item  (rot_d[i+1])
    );
  end

  awt_vec_init u_vinit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_v[CORDIC_STEPS]),
    .in_item   (rot_d[CORDIC_STEPS]),
    .out_valid (vec_v[0]),
    .out_item  (vec_d[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    awt_vec_step #(.STEP(i)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vec_v[i]),
      .in_item   (vec_d[i]),
      .out_valid (vec_v[i+1]),
      .out_item  (vec_d[i+1])
    );
  end

  awt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (vec_v[CORDIC_STEPS]),
    .in_item        (vec_d[CORDIC_STEPS]),
    .out_valid      (out_valid),
    .apparent_angle (apparent_angle),
    .apparent_speed (apparent_speed)
  );

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> apparent_angle < ANGLE_TENTHS)
    else $error("apparent angle out of range");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  a_vec_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    vec_v[0] |-> !vec_d[0].c.x[31])
    else $error("vectoring start has negative x");

endmodule

/* rtl/awt_front.sv */
// ----------------------------------------------------------------------------
// awt_front
// Three-stage front end: angle reduction, tenths to binary angle, and the
// rotation pre-step that folds the angle into +/- a quarter turn.
// ----------------------------------------------------------------------------
module awt_front import awt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [11:0] true_wind_angle,
  input  logic [10:0] true_wind_speed,
  input  logic [11:0] course_angle,
  input  logic [9:0]  ground_speed,
  output logic        out_valid,
  output rot_t        out_item
);

  function automatic logic [11:0] reduce(input logic [11:0] a);
    return (a >= ANGLE_TENTHS) ? a - ANGLE_TENTHS : a;
  endfunction

  function automatic vec_t prestep(input logic [31:0] z, input logic [31:0] mag);
    vec_t        v;
    logic [31:0] t;
    t   = z + QUARTER_TURN;
    v.y = '0;
    if (t[31]) begin
      v.x = -$signed(mag);
      v.z = z + HALF_TURN;
    end else begin
      v.x = $signed(mag);
      v.z = z;
    end
    return v;
  endfunction

  logic [11:0] wa_r, ca_r;

  // stage 0
  logic        v0;
  logic [31:0] p1_w0, p1_c0;
  logic [18:0] p2_w0, p2_c0;
  logic [10:0] tws0;
  logic [9:0]  gs0;
  logic [11:0] crs0;
  // stage 1
  logic        v1;
  logic [31:0] p1_w1, p1_c1;
  logic [37:0] q_w1, q_c1;
  logic [10:0] tws1;
  logic [9:0]  gs1;
  logic [11:0] crs1;

  logic [31:0] zw, zc;

  assign wa_r = reduce(true_wind_angle);
  assign ca_r = reduce(course_angle);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_w0 <= {20'd0, wa_r} * TURN_INT;
      p1_c0 <= {20'd0, ca_r} * TURN_INT;
      p2_w0 <= {7'd0, wa_r} * TURN_REM + TURN_RND;
      p2_c0 <= {7'd0, ca_r} * TURN_REM + TURN_RND;
      tws0  <= true_wind_speed;
      gs0   <= ground_speed;
      crs0  <= ca_r;

      p1_w1 <= p1_w0;
      p1_c1 <= p1_c0;
      q_w1  <= {19'd0, p2_w0} * RECIP_225;
      q_c1  <= {19'd0, p2_c0} * RECIP_225;
      tws1  <= tws0;
      gs1   <= gs0;
      crs1  <= crs0;

      out_item.wind   <= prestep(zw, {5'd0, tws1, 16'd0});
      out_item.boat   <= prestep(zc, {6'd0, gs1, 16'd0});
      out_item.course <= crs1;
    end
  end

  assign zw = p1_w1 + {21'd0, q_w1[37:27]};
  assign zc = p1_c1 + {21'd0, q_c1[37:27]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

endmodule

/* rtl/awt_rot_step.sv */
// ----------------------------------------------------------------------------
// awt_rot_step
// One registered CORDIC rotation iteration, applied to both vectors.
// ----------------------------------------------------------------------------
module awt_rot_step import awt_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rot_t in_item,
  output logic out_valid,
  output rot_t out_item
);

  localparam logic [31:0] ATAN = atan_turn(5'(STEP));

  function automatic vec_t iter(input vec_t v);
    vec_t               r;
    logic signed [31:0] dx, dy;
    dx = v.y >>> STEP;
    dy = v.x >>> STEP;
    if (v.z[31]) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + ATAN;
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - ATAN;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.wind   <= iter(in_item.wind);
      out_item.boat   <= iter(in_item.boat);
      out_item.course <= in_item.course;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

endmodule

/* rtl/awt_vec_init.sv */
// ----------------------------------------------------------------------------
// awt_vec_init
// Adds the two rotated vectors and applies the vectoring pre-step.
// ----------------------------------------------------------------------------
module awt_vec_init import awt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  rot_t  in_item,
  output logic  out_valid,
  output vrec_t out_item
);

  logic signed [31:0] sx, sy;

  assign sx = in_item.wind.x + in_item.boat.x;
  assign sy = in_item.wind.y + in_item.boat.y;

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.zero   <= (sx == 0) && (sy == 0);
      out_item.course <= in_item.course;
      // left half plane: flip the vector, start from a half turn
      if (sx < 0) begin
        out_item.c.x <= -sx;
        out_item.c.y <= -sy;
        out_item.c.z <= HALF_TURN;
      end else begin
        out_item.c.x <= sx;
        out_item.c.y <= sy;
        out_item.c.z <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

endmodule

/* rtl/awt_vec_step.sv */
// ----------------------------------------------------------------------------
// awt_vec_step
// One registered CORDIC vectoring iteration (drives y toward zero).
// ----------------------------------------------------------------------------
module awt_vec_step import awt_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  vrec_t in_item,
  output logic  out_valid,
  output vrec_t out_item
);

  localparam logic [31:0] ATAN = atan_turn(5'(STEP));

  logic signed [31:0] dx, dy;

  assign dx = in_item.c.y >>> STEP;
  assign dy = in_item.c.x >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.zero   <= in_item.zero;
      out_item.course <= in_item.course;
      if (in_item.c.y > 0) begin
        out_item.c.x <= in_item.c.x + dx;
        out_item.c.y <= in_item.c.y - dy;
        out_item.c.z <= in_item.c.z + ATAN;
      end else begin
        out_item.c.x <= in_item.c.x - dx;
        out_item.c.y <= in_item.c.y + dy;
        out_item.c.z <= in_item.c.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

endmodule

/* rtl/awt_back.sv */
// ----------------------------------------------------------------------------
// awt_back
// Two-stage back end: gain removal and angle scaling, then rounding,
// saturation and course-relative wrap into the output register.
// ----------------------------------------------------------------------------
module awt_back import awt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  vrec_t       in_item,
  output logic        out_valid,
  output logic [11:0] apparent_angle,
  output logic [11:0] apparent_speed
);

  logic        v0;
  logic [59:0] sprod;
  logic [43:0] dprod;
  logic        zero0;
  logic [11:0] crs0;
  logic [30:0] xc;

  logic [60:0] srnd;
  logic [43:0] drnd;
  logic [14:0] spd;
  logic [11:0] dir_raw, dir;
  logic [12:0] ang_wide;

  assign xc = in_item.c.x[31] ? '0 : in_item.c.x[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sprod <= {29'd0, xc} * {31'd0, INV_GAIN_SQ_Q30};
      dprod <= {12'd0, in_item.c.z} * {32'd0, ANGLE_TENTHS};
      zero0 <= in_item.zero;
      crs0  <= in_item.course;
    end
  end

  assign srnd     = {1'b0, sprod} + (61'd1 << (29 + FRAC_BITS));
  assign spd      = srnd[60:46];
  assign drnd     = dprod + {12'd0, HALF_TURN};
  assign dir_raw  = drnd[43:32];
  assign dir      = (zero0 || dir_raw >= ANGLE_TENTHS) ? '0 : dir_raw;
  assign ang_wide = (dir >= crs0) ? {1'b0, dir - crs0}
                                  : {1'b0, dir} + {1'b0, ANGLE_TENTHS} - {1'b0, crs0};

  always_ff @(posedge clk) begin
    if (en) begin
      apparent_speed <= (spd > {3'd0, SPEED_MAX}) ? SPEED_MAX : spd[11:0];
      apparent_angle <= ang_wide[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      out_valid <= v0;
    end
  end

endmodule

/* verif/tb_apparent_wind_from_true_wind.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_apparent_wind_from_true_wind
// Drives true wind and boat motion requests with random gaps and output
// stalls, predicts the apparent wind angle and speed in fixed point, and
// compares every result in order.
// ----------------------------------------------------------------------------
module tb_apparent_wind_from_true_wind;
  import awt_pkg::*;

  localparam int STEPS     = 16;
  localparam int LATENCY   = 2 * STEPS + 6;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1930;

  typedef struct packed {
    logic [11:0] wind_ang;
    logic [10:0] wind_spd;
    logic [11:0] course;
    logic [9:0]  gnd_spd;
  } wind_req_t;

  typedef struct packed {
    logic [11:0] ang;
    logic [11:0] spd;
  } app_wind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] true_wind_angle = '0;
  logic [10:0] true_wind_speed = '0;
  logic [11:0] course_angle = '0;
  logic [9:0]  ground_speed = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] apparent_angle;
  logic [11:0] apparent_speed;

  wind_req_t pending_reqs[$];
  app_wind_t expected_wind[$];
  int        n_fail = 0;
  bit        stim_done = 1'b0;
  bit        hold_long = 1'b0;
  int        wdog = 0;

  apparent_wind_from_true_wind #(.CORDIC_STEPS(STEPS)) i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] tenths_to_bin(logic [11:0] a);
    logic [63:0] t;
    t = 64'(a) % 3600;
    return 32'(((t << 32) + 1800) / 3600);
  endfunction

  function automatic logic [31:0] atan_tbl(int i);
    logic [31:0] t[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  task automatic rotate_vec(input longint spd, input logic [31:0] ang,
                            output longint ox, output longint oy);
    longint x, y, dx, dy;
    logic [31:0] z, q;
    x = spd << FRAC_BITS;
    y = 0;
    z = ang;
    q = z + QUARTER_TURN;
    if (q >= HALF_TURN) begin
      x = -x;
      z = z + HALF_TURN;
    end
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z[31]) begin
        x += dx; y -= dy; z = z + atan_tbl(i);
      end else begin
        x -= dx; y += dy; z = z - atan_tbl(i);
      end
    end
    ox = x;
    oy = y;
  endtask

  task automatic predict_apparent(input wind_req_t r, output app_wind_t res);
    longint wx, wy, bx, by, x, y, dx, dy;
    logic [31:0] z;
    logic [63:0] dir, spd, crs;
    logic [127:0] prod;
    rotate_vec(longint'(r.wind_spd), tenths_to_bin(r.wind_ang), wx, wy);
    rotate_vec(longint'(r.gnd_spd), tenths_to_bin(r.course), bx, by);
    x = wx + bx;
    y = wy + by;
    z = '0;
    dir = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x; y = -y; z = HALF_TURN;
      end
      for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z = z + atan_tbl(i);
        end else begin
          x -= dx; y += dy; z = z - atan_tbl(i);
        end
      end
      dir = ((64'(z) * 3600) + 64'(HALF_TURN)) >> 32;
      if (dir >= 3600) dir = 0;
    end
    if (x < 0) x = 0;
    prod = 128'(x) * 128'(INV_GAIN_SQ_Q30) + (128'(1) << (29 + FRAC_BITS));
    spd = 64'(prod >> (30 + FRAC_BITS));
    if (spd > 4095) spd = 4095;
    crs = 64'(r.course) % 3600;
    res.ang = 12'((dir + 3600 - crs) % 3600);
    res.spd = spd[11:0];
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_fail++;
  endtask

  function automatic wind_req_t make_req(int a, int s, int c, int g);
    wind_req_t r;
    r.wind_ang = 12'(a);
    r.wind_spd = 11'(s);
    r.course = 12'(c);
    r.gnd_spd = 10'(g);
    return r;
  endfunction

  initial begin
    // directed corners: extremes, zero vector, course wrap, out-of-range values
    pending_reqs.push_back(make_req(0, 0, 0, 0));
    pending_reqs.push_back(make_req(1800, 100, 0, 100));
    pending_reqs.push_back(make_req(0, 100, 1800, 100));
    pending_reqs.push_back(make_req(3599, 1279, 3599, 990));
    pending_reqs.push_back(make_req(3600, 50, 3600, 50));
    pending_reqs.push_back(make_req(0, 0, 3600, 0));
    pending_reqs.push_back(make_req(4095, 2047, 4095, 1023));
    pending_reqs.push_back(make_req(900, 1279, 900, 990));
    pending_reqs.push_back(make_req(2700, 2047, 2700, 1023));
    pending_reqs.push_back(make_req(1234, 0, 2345, 0));
    pending_reqs.push_back(make_req(0, 0, 1, 0));
    pending_reqs.push_back(make_req(3599, 1, 0, 1));
    pending_reqs.push_back(make_req(0, 1, 1800, 1));
    pending_reqs.push_back(make_req(1799, 1279, 1801, 990));
    pending_reqs.push_back(make_req(450, 2047, 450, 1023));
    pending_reqs.push_back(make_req(2047, 1024, 2048, 512));
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(make_req($urandom_range(0, 4095),
             $urandom_range(0, 2047), $urandom_range(0, 4095), $urandom_range(0, 1023)));
        1: begin
          // opposing vectors of equal speed, near-zero sum
          int c, s;
          c = $urandom_range(0, 3599);
          s = $urandom_range(0, 990);
          pending_reqs.push_back(make_req((c + 1800) % 3600, s, c, s));
        end
        default: pending_reqs.push_back(make_req($urandom_range(0, 3599),
             $urandom_range(0, 1279), $urandom_range(0, 3599), $urandom_range(0, 990)));
      endcase
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    wind_req_t r;
    app_wind_t e;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        r = {true_wind_angle, true_wind_speed, course_angle, ground_speed};
        predict_apparent(r, e);
        expected_wind.push_back(e);
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall) in_gap = $urandom_range(0, 3);
        if (in_gap > 0 || pending_reqs.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          true_wind_angle <= r.wind_ang;
          true_wind_speed <= r.wind_spd;
          course_angle <= r.course;
          ground_speed <= r.gnd_spd;
        end
      end
    end
  end

  // receiver stall: random per result, one long hold-off after a while
  int out_gap = 0;
  int n_results = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) out_gap = $urandom_range(0, 3);
      if (n_results == 300 && !hold_long) begin
        hold_long = 1'b1;
        hold_cnt = 150;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (out_gap > 0 && n_results % 400 < 300) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    app_wind_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_wind.size() == 0) begin
        report_mismatch("unexpected result, angle", apparent_angle, 0);
      end else begin
        e = expected_wind.pop_front();
        if (apparent_angle !== e.ang) report_mismatch("apparent_angle", apparent_angle, e.ang);
        if (apparent_speed !== e.spd) report_mismatch("apparent_speed", apparent_speed, e.spd);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
  end

  initial begin
    wait (!rst);
    fork
      begin
        wait (stim_done && pending_reqs.size() == 0 && !in_valid
              && expected_wind.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        wait (wdog >= WDOG_MAX);
        n_fail++;
        $display("watchdog expired");
      end
    join_any
    if (n_fail == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
